@@ design/source_lexer_stream_top_assert.svh @@
// ----------------------------------------------------------------------------
// Source lexer stream assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef SOURCE_LEXER_STREAM_TOP_ASSERT_SVH
`define SOURCE_LEXER_STREAM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SLS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SLS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// Source lexer stream package
// Token types, lexer modes, kind codes and character class helpers.
// ----------------------------------------------------------------------------
package sls_pkg;

    typedef enum logic [4:0] {
        M_IDLE   = 5'd0,
        M_SLASH  = 5'd1,
        M_LINE   = 5'd2,
        M_BLOCK  = 5'd3,
        M_BSTAR  = 5'd4,
        M_NFIRST = 5'd5,
        M_NZX    = 5'd6,
        M_NRUN   = 5'd7,
        M_P1     = 5'd8,
        M_DOT2   = 5'd9,
        M_CH0    = 5'd10,
        M_CH1    = 5'd11,
        M_CHE    = 5'd12,
        M_CHE1   = 5'd13,
        M_STR    = 5'd14,
        M_STRE   = 5'd15,
        M_IDENT  = 5'd16,
        M_ERR    = 5'd17
    } mode_t;

    localparam logic [4:0] K_INT   = 5'd0;
    localparam logic [4:0] K_CHAR  = 5'd1;
    localparam logic [4:0] K_STR   = 5'd2;
    localparam logic [4:0] K_IDENT = 5'd3;
    localparam logic [4:0] K_PUNCT = 5'd4;
    localparam logic [4:0] K_KW    = 5'd5;
    localparam logic [4:0] K_END   = 5'd17;
    localparam logic [4:0] K_ERR   = 5'd18;

    localparam int MAX_TOKENS = 4;
    localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [6:0] DIGIT_NONE = 7'd99;

    localparam logic [63:0] KW_TEXT [12] = '{
        64'("return"), 64'("if"), 64'("else"), 64'("for"), 64'("func"), 64'("var"),
        64'("extern"), 64'("sizeof"), 64'("break"), 64'("continue"), 64'("type"),
        64'("struct")
    };
    localparam int KW_LEN [12] = '{6, 2, 4, 3, 4, 3, 6, 6, 5, 8, 4, 6};

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [63:0] value;
        logic [23:0] punct;
        logic        fin;
    } tok_t;

    typedef struct packed {
        logic [2:0]       cnt;
        tok_t [3:0]       tok;
    } bun_t;

    function automatic tok_t mk_tok(logic [4:0] kind, logic [31:0] start, logic [15:0] len,
                                    logic [63:0] value, logic [23:0] punct, logic fin);
        tok_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.value = value;
        t.punct = punct;
        t.fin   = fin;
        return t;
    endfunction

    function automatic bun_t push_tok(bun_t b, tok_t t);
        bun_t r;
        r = b;
        if (r.cnt < 3'(MAX_TOKENS))
        begin
            r.tok[r.cnt[1:0]] = t;
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic p1_start(logic [7:0] c);
        return c inside {"=", "!", "<", ">", ":", "+", "-", "*", "|", "&", "."};
    endfunction

    function automatic logic single_only(logic [7:0] c);
        return c inside {"(", ")", "[", "]", "{", "}", ";", ",", "@"};
    endfunction

    function automatic logic eq_first(logic [7:0] c);
        return c inside {"=", "!", "<", ">", ":", "+", "-", "*", "/"};
    endfunction

    function automatic logic single_ok(logic [7:0] c);
        return c inside {"+", "-", "*", "/", "(", ")", "<", ">", ";", "{", "}", "=", ",",
                         "&", "[", "]", ".", "@"};
    endfunction

    function automatic logic [6:0] digit_val(logic [7:0] c);
        logic [6:0] d;
        d = DIGIT_NONE;
        if (is_digit(c))
            d = 7'(c - 8'h30);
        else if (c inside {["a":"f"]})
            d = 7'(c - 8'h57);
        else if (c inside {["A":"F"]})
            d = 7'(c - 8'h37);
        return d;
    endfunction

    function automatic logic [63:0] esc_value(logic [7:0] c);
        logic [7:0] v;
        case (c)
            "0":     v = 8'd0;
            "a":     v = 8'd7;
            "b":     v = 8'd8;
            "t":     v = 8'd9;
            "n":     v = 8'd10;
            "v":     v = 8'd11;
            "f":     v = 8'd12;
            "r":     v = 8'd13;
            default: v = c;
        endcase
        return 64'(v);
    endfunction

    function automatic logic [4:0] kw_kind(logic [63:0] win, logic [31:0] len);
        logic [4:0] k;
        k = K_IDENT;
        for (int i = 11; i >= 0; i--)
        begin
            if (len == 32'(KW_LEN[i]) && win == KW_TEXT[i])
                k = K_KW + 5'(i);
        end
        return k;
    endfunction

endpackage

@@ design/sls_front.sv @@
// ----------------------------------------------------------------------------
// Source lexer front end
// Classifies one source byte per cycle while the token queue has room and forms the tokens it completes.
// ----------------------------------------------------------------------------
module sls_front #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    input  logic             q_ready,
    output logic             push,
    output sls_pkg::bun_t    push_data
);

    localparam int PB = POSITION_BITS;
    localparam int LB = LENGTH_BITS;

    sls_pkg::mode_t   mode_reg, mode_next;
    logic [PB-1:0]    pos_reg, pos_next;
    logic [PB-1:0]    ts_reg, ts_next;
    logic [LB-1:0]    lc_reg, lc_next;
    logic [63:0]      va_reg, va_next;
    logic [63:0]      kw_reg, kw_next;
    logic [23:0]      hb_reg, hb_next;
    logic [4:0]       nb_reg, nb_next;
    sls_pkg::bun_t    bun;
    logic             accept;

    assign accept = in_valid && q_ready;

    always_comb
    begin
        sls_pkg::mode_t m;
        logic [PB-1:0]  ts;
        logic [LB-1:0]  lc;
        logic [63:0]    va;
        logic [63:0]    kw;
        logic [23:0]    hb;
        logic [4:0]     nb;
        logic           again;
        logic [6:0]     d;
        logic [4:0]     bs;
        logic [67:0]    prod;
        logic [7:0]     a;
        logic           pair;
        logic [7:0]     c;
        sls_pkg::bun_t  b;

        m  = mode_reg;
        ts = ts_reg;
        lc = lc_reg;
        va = va_reg;
        kw = kw_reg;
        hb = hb_reg;
        nb = nb_reg;
        c  = in_byte;
        b  = '0;
        d  = '0;
        bs = '0;
        prod = '0;
        a  = hb_reg[7:0];
        pair = 1'b0;
        again = 1'b1;

        if (in_end)
        begin
            again = 1'b0;
            case (mode_reg)
                sls_pkg::M_SLASH:
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT, 32'(ts_reg),
                        16'd1, 64'd0, 24'("/"), 1'b0));
                sls_pkg::M_NFIRST, sls_pkg::M_NRUN:
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_INT, 32'(ts_reg),
                        16'(lc_reg), va_reg, 24'd0, 1'b0));
                sls_pkg::M_NZX:
                begin
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_INT, 32'(ts_reg),
                        16'd1, 64'd0, 24'd0, 1'b0));
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(
                        sls_pkg::kw_kind(64'(hb_reg), 32'd1), 32'(ts_reg + PB'(1)),
                        16'd1, 64'd0, 24'd0, 1'b0));
                end
                sls_pkg::M_P1:
                begin
                    if (sls_pkg::single_ok(hb_reg[7:0]))
                        b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                            32'(ts_reg), 16'd1, 64'd0, 24'(hb_reg[7:0]), 1'b0));
                    else
                        b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_ERR,
                            32'(ts_reg), 16'd0, 64'd0, 24'd0, 1'b1));
                end
                sls_pkg::M_DOT2:
                begin
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT, 32'(ts_reg),
                        16'd1, 64'd0, 24'("."), 1'b0));
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                        32'(ts_reg + PB'(1)), 16'd1, 64'd0, 24'("."), 1'b0));
                end
                sls_pkg::M_CH0, sls_pkg::M_CH1, sls_pkg::M_CHE, sls_pkg::M_CHE1,
                sls_pkg::M_STRE:
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_ERR, 32'(ts_reg),
                        16'd0, 64'd0, 24'd0, 1'b1));
                sls_pkg::M_STR:
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_STR, 32'(ts_reg),
                        16'(lc_reg), 64'd0, 24'd0, 1'b0));
                sls_pkg::M_IDENT:
                    b = sls_pkg::push_tok(b, sls_pkg::mk_tok(
                        sls_pkg::kw_kind(kw_reg, 32'(lc_reg)), 32'(ts_reg),
                        16'(lc_reg), 64'd0, 24'd0, 1'b0));
                default:
                begin
                end
            endcase
            if (mode_reg != sls_pkg::M_ERR && b.cnt == 3'd0 ||
                mode_reg != sls_pkg::M_ERR && !b.tok[b.cnt[1:0] - 2'd1].fin)
                b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_END, 32'(pos_reg),
                    16'd0, 64'd0, 24'd0, 1'b1));
            m  = sls_pkg::M_IDLE;
            ts = '0;
            lc = '0;
            va = '0;
            kw = '0;
            hb = '0;
            nb = 5'd10;
        end

        for (int i = 0; i < 3; i++)
        begin
            if (again)
            begin
                again = 1'b0;
                case (m)
                    sls_pkg::M_IDLE:
                    begin
                        if (!sls_pkg::is_space(c))
                        begin
                            ts = pos_reg;
                            lc = LB'(1);
                            va = '0;
                            hb = 24'(c);
                            if (c == "/")
                                m = sls_pkg::M_SLASH;
                            else if (sls_pkg::is_digit(c))
                            begin
                                va = 64'(c - 8'h30);
                                m  = sls_pkg::M_NFIRST;
                            end
                            else if (c == "'")
                                m = sls_pkg::M_CH0;
                            else if (c == "\"")
                                m = sls_pkg::M_STR;
                            else if (sls_pkg::is_alpha(c))
                            begin
                                kw = 64'(c);
                                m  = sls_pkg::M_IDENT;
                            end
                            else if (sls_pkg::p1_start(c))
                                m = sls_pkg::M_P1;
                            else if (sls_pkg::single_only(c))
                                b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                    32'(pos_reg), 16'd1, 64'd0, 24'(c), 1'b0));
                            else
                            begin
                                b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_ERR,
                                    32'(pos_reg), 16'd0, 64'd0, 24'd0, 1'b1));
                                m = sls_pkg::M_ERR;
                            end
                        end
                    end
                    sls_pkg::M_SLASH:
                    begin
                        if (c == "/")
                            m = sls_pkg::M_LINE;
                        else if (c == "*")
                            m = sls_pkg::M_BLOCK;
                        else if (c == "=")
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                32'(ts), 16'd2, 64'd0, 24'h002F3D, 1'b0));
                            m = sls_pkg::M_IDLE;
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                32'(ts), 16'd1, 64'd0, 24'("/"), 1'b0));
                            m = sls_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    end
                    sls_pkg::M_LINE:
                    begin
                        if (c == 8'd10)
                            m = sls_pkg::M_IDLE;
                    end
                    sls_pkg::M_BLOCK:
                    begin
                        if (c == "*")
                            m = sls_pkg::M_BSTAR;
                    end
                    sls_pkg::M_BSTAR:
                    begin
                        if (c == "/")
                            m = sls_pkg::M_IDLE;
                        else if (c != "*")
                            m = sls_pkg::M_BLOCK;
                    end
                    sls_pkg::M_NFIRST:
                    begin
                        if (c == "b")
                        begin
                            nb = 5'd2;
                            va = '0;
                            if (lc != '1)
                                lc = lc + LB'(1);
                            m = sls_pkg::M_NRUN;
                        end
                        else if (hb == 24'("0") && (c == "x" || c == "X"))
                        begin
                            hb = 24'(c);
                            if (lc != '1)
                                lc = lc + LB'(1);
                            m = sls_pkg::M_NZX;
                        end
                        else
                        begin
                            nb = (hb == 24'("0")) ? 5'd8 : 5'd10;
                            m = sls_pkg::M_NRUN;
                            again = 1'b1;
                        end
                    end
                    sls_pkg::M_NZX:
                    begin
                        d = sls_pkg::digit_val(c);
                        if (d < 7'd16)
                        begin
                            nb = 5'd16;
                            va = 64'(d);
                            if (lc != '1)
                                lc = lc + LB'(1);
                            m = sls_pkg::M_NRUN;
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_INT,
                                32'(ts), 16'd1, 64'd0, 24'd0, 1'b0));
                            ts = ts + PB'(1);
                            lc = LB'(1);
                            kw = 64'(hb);
                            m = sls_pkg::M_IDENT;
                            again = 1'b1;
                        end
                    end
                    sls_pkg::M_NRUN:
                    begin
                        d  = sls_pkg::digit_val(c);
                        bs = (nb == 5'd0) ? 5'd10 : nb;
                        if (d < 7'(bs))
                        begin
                            case (bs)
                                5'd2:    prod = 68'(va) << 1;
                                5'd8:    prod = 68'(va) << 3;
                                5'd16:   prod = 68'(va) << 4;
                                default: prod = (68'(va) << 3) + (68'(va) << 1);
                            endcase
                            prod = prod + 68'(d);
                            if (prod > 68'(sls_pkg::VALUE_MAX))
                                va = sls_pkg::VALUE_MAX;
                            else
                                va = prod[63:0];
                            if (lc != '1)
                                lc = lc + LB'(1);
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_INT,
                                32'(ts), 16'(lc), va, 24'd0, 1'b0));
                            m = sls_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    end
                    sls_pkg::M_P1:
                    begin
                        a = hb[7:0];
                        pair = (a == "|" && c == "|") || (a == "&" && c == "&") ||
                               (a == "+" && c == "+") || (a == "-" && c == "-") ||
                               (a == "-" && c == ">");
                        if (a == "." && c == ".")
                        begin
                            hb = 24'h002E2E;
                            if (lc != '1)
                                lc = lc + LB'(1);
                            m = sls_pkg::M_DOT2;
                        end
                        else if ((c == "=" && sls_pkg::eq_first(a)) || pair)
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                32'(ts), 16'd2, 64'd0, {8'd0, a, c}, 1'b0));
                            m = sls_pkg::M_IDLE;
                        end
                        else if (sls_pkg::single_ok(a))
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                32'(ts), 16'd1, 64'd0, 24'(a), 1'b0));
                            m = sls_pkg::M_IDLE;
                            again = 1'b1;
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_ERR,
                                32'(ts), 16'd0, 64'd0, 24'd0, 1'b1));
                            m = sls_pkg::M_ERR;
                        end
                    end
                    sls_pkg::M_DOT2:
                    begin
                        if (c == ".")
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                32'(ts), 16'd3, 64'd0, 24'h2E2E2E, 1'b0));
                            m = sls_pkg::M_IDLE;
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_PUNCT,
                                32'(ts), 16'd1, 64'd0, 24'("."), 1'b0));
                            ts = ts + PB'(1);
                            lc = LB'(1);
                            hb = 24'(".");
                            m = sls_pkg::M_P1;
                            again = 1'b1;
                        end
                    end
                    sls_pkg::M_CH0:
                    begin
                        if (c == "\\")
                            m = sls_pkg::M_CHE;
                        else
                        begin
                            hb = 24'(c);
                            m = sls_pkg::M_CH1;
                        end
                    end
                    sls_pkg::M_CH1, sls_pkg::M_CHE1:
                    begin
                        if (c == "'")
                        begin
                            if (m == sls_pkg::M_CH1)
                                b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_CHAR,
                                    32'(ts), 16'd3, 64'(hb[7:0]), 24'd0, 1'b0));
                            else
                                b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_CHAR,
                                    32'(ts), 16'd4, sls_pkg::esc_value(hb[7:0]), 24'd0,
                                    1'b0));
                            m = sls_pkg::M_IDLE;
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_ERR,
                                32'(ts), 16'd0, 64'd0, 24'd0, 1'b1));
                            m = sls_pkg::M_ERR;
                        end
                    end
                    sls_pkg::M_CHE:
                    begin
                        hb = 24'(c);
                        m = sls_pkg::M_CHE1;
                    end
                    sls_pkg::M_STR:
                    begin
                        if (lc != '1)
                            lc = lc + LB'(1);
                        if (c == "\\")
                            m = sls_pkg::M_STRE;
                        else if (c == "\"")
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(sls_pkg::K_STR,
                                32'(ts), 16'(lc), 64'd0, 24'd0, 1'b0));
                            m = sls_pkg::M_IDLE;
                        end
                    end
                    sls_pkg::M_STRE:
                    begin
                        if (lc != '1)
                            lc = lc + LB'(1);
                        m = sls_pkg::M_STR;
                    end
                    sls_pkg::M_IDENT:
                    begin
                        if (sls_pkg::is_alnum(c))
                        begin
                            if (lc != '1)
                                lc = lc + LB'(1);
                            kw = {kw[55:0], c};
                        end
                        else
                        begin
                            b = sls_pkg::push_tok(b, sls_pkg::mk_tok(
                                sls_pkg::kw_kind(kw, 32'(lc)), 32'(ts), 16'(lc), 64'd0,
                                24'd0, 1'b0));
                            m = sls_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    end
                    sls_pkg::M_ERR:
                    begin
                    end
                    default:
                    begin
                        m = sls_pkg::M_IDLE;
                        again = 1'b1;
                    end
                endcase
            end
        end

        mode_next = m;
        ts_next   = ts;
        lc_next   = lc;
        va_next   = va;
        kw_next   = kw;
        hb_next   = hb;
        nb_next   = nb;
        pos_next  = in_end ? '0 : pos_reg + PB'(1);
        bun       = b;
    end

    always_comb
    begin
        in_ready  = q_ready;
        push      = accept && (bun.cnt != 3'd0);
        push_data = bun;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sls_pkg::M_IDLE;
            pos_reg  <= '0;
            ts_reg   <= '0;
            lc_reg   <= '0;
            va_reg   <= '0;
            kw_reg   <= '0;
            hb_reg   <= '0;
            nb_reg   <= 5'd10;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            lc_reg   <= lc_next;
            va_reg   <= va_next;
            kw_reg   <= kw_next;
            hb_reg   <= hb_next;
            nb_reg   <= nb_next;
        end
    end

endmodule

@@ design/sls_queue.sv @@
// ----------------------------------------------------------------------------
// Source lexer token queue
// Small FIFO of token groups between the front end and the output side.
// ----------------------------------------------------------------------------
`include "source_lexer_stream_top_assert.svh"

module sls_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sls_pkg::bun_t wr_data,
    output logic          wr_ready,
    input  logic          pop,
    output logic          rd_valid,
    output sls_pkg::bun_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sls_pkg::bun_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ready    = count_reg != CNT_W'(DEPTH);
        rd_valid    = count_reg != '0;
        rd_data     = mem[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `SLS_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, count_reg != CNT_W'(DEPTH))
    `SLS_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, count_reg != '0)
    `SLS_ASSERT_IMPL(a_group_nonempty, clk, rst_n, push, wr_data.cnt != 3'd0)
    `SLS_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

@@ design/sls_back.sv @@
// ----------------------------------------------------------------------------
// Source lexer output side
// Sends the tokens of each queued group one per cycle, while the receiver is ready, from an output register.
// ----------------------------------------------------------------------------
module sls_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sls_pkg::bun_t q_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output sls_pkg::tok_t out_tok
);

    logic [1:0]    idx_reg, idx_next;
    logic          valid_reg, valid_next;
    sls_pkg::tok_t tok_reg;
    logic          load;
    logic          last;

    always_comb
    begin
        load       = q_valid && (!valid_reg || out_ready);
        last       = (3'(idx_reg) + 3'd1) >= q_data.cnt;
        pop        = load && last;
        idx_next   = idx_reg;
        if (load)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        valid_next = load || (valid_reg && !out_ready);
        out_valid  = valid_reg;
        out_tok    = tok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            tok_reg <= q_data.tok[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ design/source_lexer_stream_top.sv @@
// ----------------------------------------------------------------------------
// Source lexer stream top level
// Streaming lexer for a small C-like language, one byte per transaction.
// ----------------------------------------------------------------------------
// The slave side takes one source byte per transaction; tlast marks the end
// of a text, and the byte of that transaction is ignored. The master side
// gives one token per transaction, with the kind in tuser and tlast set on
// the end and error tokens.
// The front end takes one byte every cycle while the token queue has room.
// A token completed by a transaction passes through the token queue into the
// output register. A byte may complete up to three tokens, and the master side
// sends them one per cycle while the receiver is ready.
// Throughput is one byte per cycle, bounded on the output side by one token
// per cycle; the queue of QUEUE_DEPTH token groups absorbs bursts.
// When the receiver stalls, the output holds and the queue fills; once it is
// full the slave side drops tready until a group leaves.
// Reset clears the lexer to its idle state with offsets at zero and empties
// the queue and the output register.
// ----------------------------------------------------------------------------
module source_lexer_stream_top #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // text_byte
    input  logic         s_axis_tlast,   // end_of_text
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // start_offset, token_length, literal_value, punct_chars
    output logic [4:0]   m_axis_tuser,   // token_kind
    output logic         m_axis_tlast    // final_token
);

    logic          push;
    sls_pkg::bun_t push_data;
    logic          q_ready;
    logic          pop;
    logic          q_valid;
    sls_pkg::bun_t q_data;
    sls_pkg::tok_t out_tok;

    sls_front #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .q_ready   (q_ready),
        .push      (push),
        .push_data (push_data)
    );

    sls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (push_data),
        .wr_ready (q_ready),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    sls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (out_tok)
    );

    assign m_axis_tdata = {out_tok.punct, out_tok.value, out_tok.len, out_tok.start};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.fin;

endmodule
